// File: design/mtmf_pkg.sv
package mtmf_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int WIN_LEN      = 10;
  localparam int CHAN_W       = 3;
  localparam int SAMPLE_W     = 16;
  localparam int SLOT_W       = 4;
  localparam int DEPTH        = NUM_CHANNELS * WIN_LEN;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // ten 16-bit entries need four extra bits
  localparam int SUM_W        = SAMPLE_W + 4;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hffff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h0000;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic clear;
    logic en;
  } acc_ctrl_t;

endpackage

// File: design/mtmf_trim_acc.sv
module mtmf_trim_acc (
  input  logic                             clk_i,
  input  mtmf_pkg::acc_ctrl_t              ctrl_i,
  input  logic [mtmf_pkg::SAMPLE_W-1:0]    entry_i,
  output logic [mtmf_pkg::SAMPLE_W-1:0]    filtered_o
);

  logic [mtmf_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [mtmf_pkg::SAMPLE_W-1:0] lo_q, lo_d;
  logic [mtmf_pkg::SAMPLE_W-1:0] hi_q, hi_d;
  logic [mtmf_pkg::SUM_W-1:0]    trimmed;

  always_comb begin
    sum_d = sum_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      lo_d  = mtmf_pkg::SAMPLE_MAX;
      hi_d  = mtmf_pkg::SAMPLE_MIN;
    end else if (ctrl_i.en) begin
      sum_d = sum_q + mtmf_pkg::SUM_W'(entry_i);
      if (entry_i < lo_q) begin
        lo_d = entry_i;
      end
      if (entry_i > hi_q) begin
        hi_d = entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  // drop min and max, then divide by eight
  assign trimmed    = sum_q - mtmf_pkg::SUM_W'(lo_q) - mtmf_pkg::SUM_W'(hi_q);
  assign filtered_o = trimmed[mtmf_pkg::SAMPLE_W+2:3];

endmodule

// File: design/multichannel_trimmed_mean_filter_core.sv
// Trimmed-mean filter for up to eight converter channels. Each input transfer carries a
// 16-bit sample in tdata and its channel in tuser; the sample replaces the oldest of that
// channel's ten window entries, and one result transfer follows carrying the window sum
// minus its smallest and largest entry, divided by eight and truncated, with the channel
// echoed in tuser. Windows start as all zeros after reset, so the first nine results of a
// channel include zero entries. No new sample is taken until an item has passed the accept
// cycle, ten reads of the window memory through its single read port, a step to take the
// last read word and the output register load, held while a prior result is unaccepted. The
// loaded result then waits in that register, so the next sample is taken while it is pending.
module multichannel_trimmed_mean_filter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mtmf_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
  input  logic [mtmf_pkg::CHAN_W-1:0]   s_axis_tuser,  // [2:0] chan
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mtmf_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [15:0] filtered
  output logic [mtmf_pkg::CHAN_W-1:0]   m_axis_tuser   // [2:0] out_chan
);

  mtmf_pkg::state_e state_q, state_d;

  logic [mtmf_pkg::SAMPLE_W-1:0] mem [mtmf_pkg::DEPTH];
  logic [mtmf_pkg::DEPTH-1:0]    written_q;
  logic [mtmf_pkg::SLOT_W-1:0]   slot_q [mtmf_pkg::NUM_CHANNELS];

  logic                          s_xfer;
  logic                          m_xfer;
  logic                          in_range;
  logic [mtmf_pkg::CH_IDX_W-1:0] ch_idx;
  logic [mtmf_pkg::SLOT_W-1:0]   cur_slot;
  logic [mtmf_pkg::SLOT_W-1:0]   next_slot;
  logic [mtmf_pkg::ADDR_W-1:0]   base;
  logic [mtmf_pkg::ADDR_W-1:0]   wr_addr;
  logic                          wr_en;

  logic [mtmf_pkg::ADDR_W-1:0]   base_q;
  logic [mtmf_pkg::CHAN_W-1:0]   chan_q;
  logic                          ok_q;
  logic [mtmf_pkg::SLOT_W-1:0]   k_q;
  logic                          rd_en;
  logic [mtmf_pkg::ADDR_W-1:0]   rd_addr;
  logic [mtmf_pkg::SAMPLE_W-1:0] rd_data_q;
  logic                          rd_written_q;
  logic                          rd_pend_q;
  logic [mtmf_pkg::SAMPLE_W-1:0] entry;

  mtmf_pkg::acc_ctrl_t           acc_ctrl;
  logic [mtmf_pkg::SAMPLE_W-1:0] acc_result;
  logic                          load_out;

  logic                          out_valid_q;
  logic [mtmf_pkg::SAMPLE_W-1:0] out_data_q;
  logic [mtmf_pkg::CHAN_W-1:0]   out_chan_q;

  assign s_axis_tready = (state_q == mtmf_pkg::S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = out_valid_q && m_axis_tready;

  assign in_range  = int'(s_axis_tuser) < mtmf_pkg::NUM_CHANNELS;
  assign ch_idx    = mtmf_pkg::CH_IDX_W'(s_axis_tuser);
  // out-of-range codes in the slot register restart the window at entry zero
  assign cur_slot  = (int'(slot_q[ch_idx]) >= mtmf_pkg::WIN_LEN) ? '0 : slot_q[ch_idx];
  assign next_slot = (int'(cur_slot) == mtmf_pkg::WIN_LEN - 1) ? '0 : cur_slot + 1'b1;
  assign base      = mtmf_pkg::ADDR_W'(ch_idx) * mtmf_pkg::ADDR_W'(mtmf_pkg::WIN_LEN);
  assign wr_addr   = base + mtmf_pkg::ADDR_W'(cur_slot);
  assign wr_en     = s_xfer && in_range;

  assign rd_en   = (state_q == mtmf_pkg::S_READ);
  assign rd_addr = base_q + mtmf_pkg::ADDR_W'(k_q);
  assign entry   = rd_written_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      for (int i = 0; i < mtmf_pkg::NUM_CHANNELS; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        written_q[wr_addr] <= 1'b1;
        slot_q[ch_idx]     <= next_slot;
      end
      if (rd_en) begin
        rd_written_q <= written_q[rd_addr];
      end
    end
  end

  assign acc_ctrl.clear = s_xfer;
  assign acc_ctrl.en    = rd_pend_q;

  mtmf_trim_acc u_acc (
    .clk_i      (clk_i),
    .ctrl_i     (acc_ctrl),
    .entry_i    (entry),
    .filtered_o (acc_result)
  );

  assign load_out = (state_q == mtmf_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mtmf_pkg::S_IDLE: begin
        if (s_xfer) begin
          state_d = mtmf_pkg::S_READ;
        end
      end
      mtmf_pkg::S_READ: begin
        if (int'(k_q) == mtmf_pkg::WIN_LEN - 1) begin
          state_d = mtmf_pkg::S_DRAIN;
        end
      end
      mtmf_pkg::S_DRAIN: begin
        state_d = mtmf_pkg::S_DONE;
      end
      mtmf_pkg::S_DONE: begin
        if (load_out) begin
          state_d = mtmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mtmf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtmf_pkg::S_IDLE;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
      if (s_xfer) begin
        k_q <= '0;
      end else if (rd_en) begin
        k_q <= k_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      base_q <= base;
      chan_q <= s_axis_tuser;
      ok_q   <= in_range;
    end
    if (load_out) begin
      out_data_q <= ok_q ? acc_result : '0;
      out_chan_q <= chan_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_chan_q;

endmodule

// File: bench/multichannel_trimmed_mean_filter_core_tb.sv
`timescale 1ns / 1ps

module multichannel_trimmed_mean_filter_core_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_TAIL   = 80;   // last items sent and received without idling
  localparam int HOLD_AFTER   = 200;  // results seen before the long output stall
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    STYLE_ANY,
    STYLE_LOW,
    STYLE_HIGH,
    STYLE_RUN
  } sample_style_e;

  typedef struct packed {
    logic [mtmf_pkg::CHAN_W-1:0]   chan;
    logic [mtmf_pkg::SAMPLE_W-1:0] value;
  } chan_value_t;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mtmf_pkg::SAMPLE_W-1:0] s_axis_tdata  = '0;  // [15:0] sample
  logic [mtmf_pkg::CHAN_W-1:0]   s_axis_tuser  = '0;  // [2:0] chan
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mtmf_pkg::SAMPLE_W-1:0] m_axis_tdata;        // [15:0] filtered
  logic [mtmf_pkg::CHAN_W-1:0]   m_axis_tuser;        // [2:0] out_chan

  chan_value_t sample_backlog[$];
  chan_value_t expected_averages[$];

  logic [mtmf_pkg::SAMPLE_W-1:0] windows[mtmf_pkg::NUM_CHANNELS][mtmf_pkg::WIN_LEN];
  logic [mtmf_pkg::SLOT_W-1:0]   next_slot[mtmf_pkg::NUM_CHANNELS];

  int samples_queued  = 0;
  int samples_taken   = 0;
  int results_checked = 0;
  int fault_count     = 0;
  int idle_cycles     = 0;
  int gap_left        = 0;
  int stall_left      = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  multichannel_trimmed_mean_filter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic bit quiet();
    return sample_backlog.size() < QUIET_TAIL;
  endfunction

  // Overwrite the oldest entry of the channel, then average the window without min and max.
  function automatic logic [mtmf_pkg::SAMPLE_W-1:0] window_average(
      input logic [mtmf_pkg::CHAN_W-1:0]   ch,
      input logic [mtmf_pkg::SAMPLE_W-1:0] smp);
    logic [mtmf_pkg::SUM_W-1:0]    total;
    logic [mtmf_pkg::SAMPLE_W-1:0] lo;
    logic [mtmf_pkg::SAMPLE_W-1:0] hi;
    logic [mtmf_pkg::SLOT_W-1:0]   slot;
    slot = (next_slot[ch] >= mtmf_pkg::WIN_LEN) ? '0 : next_slot[ch];
    windows[ch][slot] = smp;
    next_slot[ch] = (slot == mtmf_pkg::WIN_LEN - 1) ? '0 : slot + 1'b1;
    total = '0;
    lo = mtmf_pkg::SAMPLE_MAX;
    hi = mtmf_pkg::SAMPLE_MIN;
    for (int k = 0; k < mtmf_pkg::WIN_LEN; k++) begin
      total += windows[ch][k];
      if (windows[ch][k] > hi) hi = windows[ch][k];
      if (windows[ch][k] < lo) lo = windows[ch][k];
    end
    total = total - lo - hi;
    return total[mtmf_pkg::SAMPLE_W+2:3];
  endfunction

  task automatic queue_sample(input int ch, input int smp);
    sample_backlog.push_back('{chan: mtmf_pkg::CHAN_W'(ch), value: mtmf_pkg::SAMPLE_W'(smp)});
    samples_queued++;
  endtask

  // Sender: present backlog items, with short random gaps outside the quiet tail.
  always @(posedge clk_i or negedge rst_ni) begin
    chan_value_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (sample_backlog.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet() && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= $urandom_range(0, 4);
      end else begin
        item = sample_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.value;
        s_axis_tuser  <= item.chan;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && results_checked >= HOLD_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES - 1;
      hold_done     <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!quiet() && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on every input transfer, check every output transfer, watch for a hang.
  always @(posedge clk_i) begin
    chan_value_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_averages.push_back('{chan: s_axis_tuser,
                                      value: window_average(s_axis_tuser, s_axis_tdata)});
        samples_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: chan %0d filtered 0x%04h",
                     $realtime, m_axis_tuser, m_axis_tdata);
        end else begin
          want = expected_averages.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.chan) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("[%0t] result %0d: expected chan %0d 0x%04h, got chan %0d 0x%04h",
                       $realtime, results_checked, want.chan, want.value,
                       m_axis_tuser, m_axis_tdata);
          end
        end
        results_checked++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("multichannel_trimmed_mean_filter_core verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int            ch;
    int            base;
    int            run_len;
    sample_style_e style;

    for (int c = 0; c < mtmf_pkg::NUM_CHANNELS; c++) begin
      next_slot[c] = '0;
      for (int k = 0; k < mtmf_pkg::WIN_LEN; k++) windows[c][k] = '0;
    end

    // Warm-up to a full window of all ones, then wrap the oldest slot with a zero.
    for (int k = 0; k < mtmf_pkg::WIN_LEN; k++) queue_sample(0, 16'hffff);
    queue_sample(0, 16'h0000);
    queue_sample(7, 16'h0000);
    queue_sample(7, 16'hffff);
    queue_sample(7, 16'h8000);
    queue_sample(7, 16'h7fff);
    for (int c = 1; c < mtmf_pkg::NUM_CHANNELS - 1; c++) queue_sample(c, 1 << (c * 2 + 1));

    while (samples_queued < RANDOM_ITEMS + 21) begin
      ch    = $urandom_range(0, mtmf_pkg::NUM_CHANNELS - 1);
      style = sample_style_e'($urandom_range(0, 3));
      case (style)
        STYLE_ANY:  queue_sample(ch, $urandom_range(0, 16'hffff));
        STYLE_LOW:  queue_sample(ch, $urandom_range(0, 15));
        STYLE_HIGH: queue_sample(ch, $urandom_range(16'hfff0, 16'hffff));
        STYLE_RUN: begin
          // steady signal with small noise and an occasional spike, long enough to fill a window
          base    = $urandom_range(0, 16'hffff);
          run_len = $urandom_range(mtmf_pkg::WIN_LEN, mtmf_pkg::WIN_LEN + 4);
          for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 9) == 0)
              queue_sample(ch, $urandom_range(0, 1) ? 16'hffff : 16'h0000);
            else
              queue_sample(ch, (base + $urandom_range(0, 7)) & 16'hffff);
          end
        end
        default: queue_sample(ch, 0);
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_taken < samples_queued || expected_averages.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d samples over %0d channels and checked %0d filtered results,",
             samples_taken, mtmf_pkg::NUM_CHANNELS, results_checked);
    $display("covering warm-up, full-scale windows, steady runs with spikes and a long output stall.");
    if (fault_count == 0) begin
      $display("multichannel_trimmed_mean_filter_core verification clean");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("multichannel_trimmed_mean_filter_core verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/mtmf_pkg.sv
design/mtmf_trim_acc.sv
design/multichannel_trimmed_mean_filter_core.sv
bench/multichannel_trimmed_mean_filter_core_tb.sv
